/* rtl/itf_pkg.sv */
// Package with shared types, constants and a helper function of the integer-to-text formatter.
`default_nettype none
package itf_pkg;

	localparam int MaxChars  = 64;
	localparam int ValueBits = 64;
	localparam int CharLimit = (MaxChars < 64) ? MaxChars : 64;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_BAD_RADIX = 2'd1;
	localparam logic [1:0] STATUS_TRUNC     = 2'd2;

	// Output segments in emission order.
	typedef enum logic [2:0] {
		SEG_LEAD  = 3'd0,
		SEG_SIGN  = 3'd1,
		SEG_PFX   = 3'd2,
		SEG_ZPAD  = 3'd3,
		SEG_PREC  = 3'd4,
		SEG_DIG   = 3'd5,
		SEG_TRAIL = 3'd6,
		SEG_DONE  = 3'd7
	} seg_t;

	typedef struct packed {
		logic [63:0] value;
		logic [5:0]  radix;
		logic [5:0]  fmt_width;
		logic [5:0]  min_digits;
		logic        lower_case;
		logic        left_align;
		logic        zero_pad;
		logic        signed_value;
		logic        plus_sign;
		logic        space_sign;
		logic        alt_prefix;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last;
		logic [1:0] status;
	} out_word_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture the input word
		logic div_go;  // run one digit division
		logic plan;    // compute segment lengths
		logic emit;    // emit one character
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic bad_radix;
		logic div_busy;
		logic conv_done; // value is zero after last digit
		logic emit_done; // last character sent
	} dp_stat_t;

	function automatic logic [7:0] digit_char(input logic [5:0] d, input logic lc);
		logic [7:0] c;
		begin
			if (d < 6'd10) c = 8'h30 + {2'b00, d};
			else if (lc)   c = 8'h61 + {2'b00, d} - 8'd10;
			else           c = 8'h41 + {2'b00, d} - 8'd10;
			return c;
		end
	endfunction

endpackage
`default_nettype wire

/* rtl/itf_divider.sv */
// Bit-serial restoring divider that splits off one digit of the value per run.
`default_nettype none
module itf_divider
	import itf_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 go,
	input  wire logic [ValueBits-1:0] dividend,
	input  wire logic [5:0]           divisor,
	output logic                      busy,
	output logic                      done,
	output logic [ValueBits-1:0]      quotient,
	output logic [5:0]                remainder
);

	localparam int CntW = $clog2(ValueBits + 1);

	logic [ValueBits-1:0] quo_q;
	logic [6:0]           rem_q;
	logic [CntW-1:0]      cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [6:0]           shifted;
	logic                 fits;

	assign shifted = {rem_q[5:0], quo_q[ValueBits-1]};
	assign fits    = shifted >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CntW'(1));
			if (go && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(ValueBits);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && !busy_q) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[ValueBits-2:0], fits};
			rem_q <= fits ? (shifted - {1'b0, divisor}) : shifted;
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q[5:0];

endmodule
`default_nettype wire

/* rtl/itf_datapath.sv */
// Datapath: operand registers, digit store, segment counters and character selection.
`default_nettype none
module itf_datapath
	import itf_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire in_word_t  in_word,
	input  wire ctl_cmd_t  cmd,
	output dp_stat_t       stat,
	output logic           out_valid,
	output out_word_t      out_word
);

	in_word_t             op_q;
	logic [ValueBits-1:0] num_q;
	logic [5:0]           store_q [64];
	logic [6:0]           ndig_q;
	logic [6:0]           rd_idx_q;
	logic [6:0]           rd_idx_d;
	logic [5:0]           rd_dig_q;
	logic                 conv_done_q;

	logic [7:0]  lead_q, zpad_q, trail_q, prec_q;
	logic [1:0]  pfx_q;
	logic        has_sign_q;
	logic [7:0]  sign_char_q;
	seg_t        seg_q;
	logic [7:0]  seg_cnt_q;
	logic [6:0]  emitted_q;
	logic        emit_done_q;
	logic        out_valid_q;
	out_word_t   out_q;

	logic                 div_busy, div_done;
	logic [ValueBits-1:0] quo;
	logic [5:0]           rem;

	logic                 neg;
	logic [ValueBits-1:0] masked;
	in_word_t             load_word;
	logic                 load_bad;

	assign masked   = in_word.value[ValueBits-1:0];
	assign neg      = in_word.signed_value && masked[ValueBits-1];
	assign load_bad = in_word.radix < 6'd2 || in_word.radix > 6'd36;

	// Left alignment overrides zero padding.
	always_comb begin
		load_word          = in_word;
		load_word.zero_pad = in_word.zero_pad && !in_word.left_align;
	end

	// Read address of the digit store, one step ahead of the character it feeds.
	always_comb begin
		rd_idx_d = rd_idx_q;
		if (cmd.plan) rd_idx_d = ndig_q - 7'd1;
		else if (cmd.emit && !emit_done_q && seg_q == SEG_DIG) rd_idx_d = rd_idx_q - 7'd1;
	end

	itf_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.div_go),
		.dividend (num_q),
		.divisor  (op_q.radix),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quo),
		.remainder(rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= load_word;
			num_q <= neg ? (ValueBits'(0) - masked) : masked;
		end else if (div_done) begin
			num_q <= quo;
			store_q[ndig_q[5:0]] <= rem;
		end
		rd_dig_q <= store_q[rd_idx_d[5:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ndig_q      <= '0;
			conv_done_q <= 1'b0;
		end else if (cmd.load) begin
			ndig_q      <= '0;
			conv_done_q <= 1'b0;
		end else if (div_done) begin
			ndig_q      <= ndig_q + 1'b1;
			conv_done_q <= (quo == '0) || (ndig_q == 7'd63);
		end
	end

	// Segment planning, all from registered operands.
	logic signed [8:0] size_w, prec_w, rest_w;
	logic              sgn_on;
	logic [1:0]        pfx_w;
	logic [7:0]        sch_w;
	always_comb begin
		sgn_on = 1'b0;
		sch_w  = 8'h2D;
		if (op_q.signed_value) begin
			if (op_q.value[ValueBits-1])  begin sgn_on = 1'b1; sch_w = 8'h2D; end
			else if (op_q.plus_sign)       begin sgn_on = 1'b1; sch_w = 8'h2B; end
			else if (op_q.space_sign)      begin sgn_on = 1'b1; sch_w = 8'h20; end
		end
		pfx_w = 2'd0;
		if (op_q.alt_prefix) begin
			if (op_q.radix == 6'd8)  pfx_w = 2'd1;
			if (op_q.radix == 6'd16) pfx_w = 2'd2;
		end
		prec_w = ({3'b0, op_q.min_digits} > {2'b0, ndig_q}) ?
			{3'b0, op_q.min_digits} : {2'b0, ndig_q};
		size_w = {3'b0, op_q.fmt_width} - {8'b0, sgn_on} - {7'b0, pfx_w};
		rest_w = size_w - prec_w;
	end

	logic [7:0] pad_w;
	assign pad_w = rest_w > 0 ? rest_w[7:0] : 8'd0;

	// First segment with a nonzero length at or after the given one.
	function automatic seg_t next_seg(input seg_t s, input logic [7:0] le,
		input logic hs, input logic [1:0] pf, input logic [7:0] zp,
		input logic [7:0] pr, input logic [7:0] tr);
		seg_t n;
		begin
			n = SEG_DONE;
			if (s == SEG_LEAD && le != 0)                        n = SEG_LEAD;
			else if (s <= SEG_SIGN && hs)                        n = SEG_SIGN;
			else if (s <= SEG_PFX && pf != 0)                    n = SEG_PFX;
			else if (s <= SEG_ZPAD && zp != 0)                   n = SEG_ZPAD;
			else if (s <= SEG_PREC && pr != 0)                   n = SEG_PREC;
			else if (s <= SEG_DIG)                               n = SEG_DIG;
			else if (s <= SEG_TRAIL && tr != 0)                  n = SEG_TRAIL;
			return n;
		end
	endfunction

	function automatic logic [7:0] seg_len(input seg_t s, input logic [7:0] le,
		input logic [1:0] pf, input logic [7:0] zp, input logic [7:0] pr,
		input logic [7:0] tr, input logic [6:0] nd);
		logic [7:0] l;
		begin
			case (s)
				SEG_LEAD:  l = le;
				SEG_SIGN:  l = 8'd1;
				SEG_PFX:   l = {6'b0, pf};
				SEG_ZPAD:  l = zp;
				SEG_PREC:  l = pr;
				SEG_DIG:   l = {1'b0, nd};
				SEG_TRAIL: l = tr;
				default:   l = 8'd0;
			endcase
			return l;
		end
	endfunction

	// Character of the current position.
	logic [7:0] ch;
	always_comb begin
		case (seg_q) inside
			SEG_LEAD, SEG_TRAIL: ch = 8'h20;
			SEG_SIGN:            ch = sign_char_q;
			SEG_PFX:             ch = (pfx_q == 2'd2 && seg_cnt_q == 8'd1) ?
				(op_q.lower_case ? 8'h78 : 8'h58) : 8'h30;
			SEG_DIG:             ch = digit_char(rd_dig_q, op_q.lower_case);
			default:             ch = 8'h30;
		endcase
	end

	seg_t        nseg;
	logic [7:0]  nlen;
	logic        seg_end, text_end, cap_hit;
	assign seg_end  = seg_q == SEG_PFX ? (seg_cnt_q == 8'd1 || pfx_q == 2'd1) :
		seg_cnt_q == 8'd1;
	assign nseg     = next_seg(seg_t'(seg_q + 3'd1), lead_q, has_sign_q, pfx_q,
		zpad_q, prec_q, trail_q);
	assign nlen     = seg_len(nseg, lead_q, pfx_q, zpad_q, prec_q, trail_q, ndig_q);
	assign text_end = seg_end && nseg == SEG_DONE;
	assign cap_hit  = emitted_q == 7'(CharLimit - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q       <= SEG_DONE;
			emitted_q   <= '0;
			emit_done_q <= 1'b0;
			out_valid_q <= 1'b0;
			rd_idx_q    <= '0;
		end else begin
			out_valid_q <= (cmd.load && load_bad) || (cmd.emit && !emit_done_q);
			if (cmd.load) begin
				emit_done_q <= load_bad;
				seg_q       <= SEG_DONE;
				if (load_bad) begin
					out_q <= '{out_char: 8'h00, last: 1'b1, status: STATUS_BAD_RADIX};
				end
			end else if (cmd.plan) begin
				lead_q      <= (!op_q.zero_pad && !op_q.left_align) ? pad_w : 8'd0;
				zpad_q      <= op_q.zero_pad ? pad_w : 8'd0;
				trail_q     <= op_q.left_align ? pad_w : 8'd0;
				prec_q      <= prec_w[7:0] - {1'b0, ndig_q};
				pfx_q       <= pfx_w;
				has_sign_q  <= sgn_on;
				sign_char_q <= sch_w;
				emitted_q   <= '0;
				rd_idx_q    <= ndig_q - 1'b1;
				seg_q       <= next_seg(SEG_LEAD, (!op_q.zero_pad && !op_q.left_align) ?
					pad_w : 8'd0, sgn_on, pfx_w, op_q.zero_pad ? pad_w : 8'd0,
					prec_w[7:0] - {1'b0, ndig_q}, 8'd0);
				seg_cnt_q   <= seg_len(next_seg(SEG_LEAD, (!op_q.zero_pad &&
					!op_q.left_align) ? pad_w : 8'd0, sgn_on, pfx_w,
					op_q.zero_pad ? pad_w : 8'd0, prec_w[7:0] - {1'b0, ndig_q}, 8'd0),
					(!op_q.zero_pad && !op_q.left_align) ? pad_w : 8'd0, pfx_w,
					op_q.zero_pad ? pad_w : 8'd0, prec_w[7:0] - {1'b0, ndig_q}, 8'd0,
					ndig_q);
			end else if (cmd.emit && !emit_done_q) begin
				out_q.out_char <= ch;
				out_q.last     <= text_end || cap_hit;
				out_q.status   <= (cap_hit && !text_end) ? STATUS_TRUNC : STATUS_OK;
				emitted_q      <= emitted_q + 1'b1;
				if (text_end || cap_hit) emit_done_q <= 1'b1;
				if (seg_q == SEG_DIG) rd_idx_q <= rd_idx_q - 1'b1;
				if (seg_end) begin
					seg_q     <= nseg;
					seg_cnt_q <= nlen;
				end else begin
					seg_cnt_q <= seg_cnt_q - 1'b1;
				end
			end
		end
	end

	assign stat.bad_radix = op_q.radix < 6'd2 || op_q.radix > 6'd36;
	assign stat.div_busy  = div_busy || div_done;
	assign stat.conv_done = conv_done_q;
	assign stat.emit_done = emit_done_q;
	assign out_valid      = out_valid_q;
	assign out_word       = out_q;

`ifndef SYNTH
	a_no_emit_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		emit_done_q && !cmd.load && !cmd.plan |=> !out_valid_q)
		else $error("character emitted after last");
	a_last_sets_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.last |-> emit_done_q)
		else $error("last word without done flag");
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		emitted_q <= 7'(CharLimit))
		else $error("character limit exceeded");
`endif

endmodule
`default_nettype wire

/* rtl/itf_ctrl.sv */
// Controller state machine sequencing load, digit conversion, planning and emission.
`default_nettype none
module itf_ctrl
	import itf_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire dp_stat_t stat,
	output ctl_cmd_t      cmd,
	output logic          busy
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_CHK  = 6'b000010,
		ST_DIV  = 6'b000100,
		ST_WAIT = 6'b001000,
		ST_PLAN = 6'b010000,
		ST_EMIT = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_CHK;
				end
			end
			ST_CHK: begin
				state_d = stat.bad_radix ? ST_IDLE : ST_DIV;
			end
			ST_DIV: begin
				cmd.div_go = 1'b1;
				state_d    = ST_WAIT;
			end
			ST_WAIT: begin
				if (!stat.div_busy) state_d = stat.conv_done ? ST_PLAN : ST_DIV;
			end
			ST_PLAN: begin
				cmd.plan = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (stat.emit_done) begin
					cmd.emit = 1'b0;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	assign busy = state_q != ST_IDLE;

`ifndef SYNTH
	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == ST_IDLE)
		else $error("load outside idle");
	a_load_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> busy)
		else $error("busy not raised after load");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("several commands at once");
`endif

endmodule
`default_nettype wire

/* rtl/integer_to_text_formatter_core.sv */
// Top level of the integer-to-text formatter: controller plus datapath.
`default_nettype none
// Channel   | Handshake          | Word
// ----------+--------------------+-------------------------------------
// input     | start & !busy      | in_word  (in_word_t)
// result    | out_valid (strobe) | out_word (out_word_t)
//
// After acceptance busy stays high through a check state, then for each digit
// (at least one) a launch state, the steps of the shared bit-serial divider, one
// per value bit, a done step and a decision state, then a planning state, the
// emission of one character per cycle and a closing state. An invalid radix keeps
// busy high for one cycle and gives its single error word in the cycle right
// after acceptance.
// arst_n clears the controller and all valid flags at once; the digit store
// holds no reset value. The receiver cannot stall: each word is shown once.
module integer_to_text_formatter_core
	import itf_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire in_word_t in_word,
	output logic          busy,
	output logic          out_valid,
	output out_word_t     out_word
);

	// Command and status groups between the controller and the datapath.
	ctl_cmd_t cmd;
	dp_stat_t stat;

	itf_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy)
	);

	itf_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_word  (in_word),
		.cmd      (cmd),
		.stat     (stat),
		.out_valid(out_valid),
		.out_word (out_word)
	);

`ifndef SYNTH
	a_no_out_idle_long: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !$past(busy) |-> !out_valid)
		else $error("word emitted while idle");
	a_ok_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.last |-> out_word.status == STATUS_OK)
		else $error("status on non-final word");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.status != 2'd3)
		else $error("undefined status code");
`endif

endmodule
`default_nettype wire
